/* rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DataW     = 16;  // element and component width
  localparam int BaseW     = 17;  // clamped base, always positive
  localparam int RadW      = 38;  // radicand: base shifted up by 20, padded even
  localparam int RootW     = 19;  // sqrt result width
  localparam int SqRemW    = 21;  // sqrt partial remainder
  localparam int SqrtSteps = RootW;
  localparam int MagW      = 17;  // off-diagonal pair magnitude
  localparam int NumW      = 34;  // rounded dividend
  localparam int DenW      = 20;  // divisor, twice the root
  localparam int QuoW      = 23;  // quotient bits, also division steps
  localparam int DivSteps  = QuoW;
  localparam int Lanes     = 3;   // minor components per item
  localparam int MajW      = 15;  // major component magnitude

  typedef enum logic [1:0] {
    MAJ_W,
    MAJ_X,
    MAJ_Y,
    MAJ_Z
  } major_t;

  typedef struct packed {
    logic signed [DataW-1:0] m00;
    logic signed [DataW-1:0] m01;
    logic signed [DataW-1:0] m02;
    logic signed [DataW-1:0] m10;
    logic signed [DataW-1:0] m11;
    logic signed [DataW-1:0] m12;
    logic signed [DataW-1:0] m20;
    logic signed [DataW-1:0] m21;
    logic signed [DataW-1:0] m22;
  } in_req_t;

  typedef struct packed {
    logic signed [DataW-1:0] quat_w;
    logic signed [DataW-1:0] quat_x;
    logic signed [DataW-1:0] quat_y;
    logic signed [DataW-1:0] quat_z;
  } out_req_t;

  // data riding along the sqrt chain
  typedef struct packed {
    major_t                      major;
    logic [Lanes-1:0]            neg;
    logic [Lanes-1:0][MagW-1:0]  mag;
  } sq_side_t;

  // data riding along the divider chain
  typedef struct packed {
    major_t            major;
    logic [Lanes-1:0]  neg;
    logic [MajW-1:0]   major_val;
  } dv_side_t;

endpackage

/* rtl/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a Q2.14 rotation matrix to a Q2.14 unit quaternion.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries the nine matrix elements, row-major; a request is taken
//   when in_valid is high and in_stall low. out_data carries w, x, y, z; the
//   receiver takes it when out_valid is high and out_stall low.
//   The chain has one prep stage, 19 square root cells, one rounding stage,
//   23 divider cells and the output register.
//   Throughput is one request per cycle while the chain is not held; the whole
//   chain of cells moves together, so one item per cycle is set by the single shared advance.
//   While the output register holds an untaken result and out_stall is high,
//   the chain holds and in_stall is raised; otherwise in_stall stays low.
//   Reset clears all valid bits; the chain comes up empty and ready.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rmq_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rmq_pkg::out_req_t out_data
);

  localparam int SQW = $bits(rmq_pkg::sq_side_t);
  localparam int DVW = $bits(rmq_pkg::dv_side_t);
  localparam int L   = rmq_pkg::Lanes;

  logic adv;
  logic out_valid_r;
  rmq_pkg::out_req_t out_data_r;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- prep stage ----------------
  logic signed [18:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [18:0] tr, b_raw;
  logic signed [18:0] p_zyx, p_xzy, p_yxz, s_xy, s_xz, s_yz;
  logic signed [18:0] pr [L];
  rmq_pkg::major_t    major_c;
  rmq_pkg::sq_side_t  side_c;
  logic [rmq_pkg::BaseW-1:0] base_c;

  always_comb begin
    e00 = 19'(in_data.m00);
    e01 = 19'(in_data.m01);
    e02 = 19'(in_data.m02);
    e10 = 19'(in_data.m10);
    e11 = 19'(in_data.m11);
    e12 = 19'(in_data.m12);
    e20 = 19'(in_data.m20);
    e21 = 19'(in_data.m21);
    e22 = 19'(in_data.m22);
    tr    = e00 + e11 + e22;
    p_zyx = e21 - e12;
    p_xzy = e02 - e20;
    p_yxz = e10 - e01;
    s_xy  = e01 + e10;
    s_xz  = e02 + e20;
    s_yz  = e12 + e21;
  end

  // branch choice and pair selection
  always_comb begin
    priority if (tr > 19'sd0) begin
      major_c = rmq_pkg::MAJ_W;
      b_raw   = tr + 19'sd16384;
      pr[0] = p_zyx; pr[1] = p_xzy; pr[2] = p_yxz;
    end else if (in_data.m00 > in_data.m11 && in_data.m00 > in_data.m22) begin
      major_c = rmq_pkg::MAJ_X;
      b_raw   = 19'sd16384 + e00 - e11 - e22;
      pr[0] = p_zyx; pr[1] = s_xy; pr[2] = s_xz;
    end else if (in_data.m11 > in_data.m22) begin
      major_c = rmq_pkg::MAJ_Y;
      b_raw   = 19'sd16384 + e11 - e00 - e22;
      pr[0] = p_xzy; pr[1] = s_xy; pr[2] = s_yz;
    end else begin
      major_c = rmq_pkg::MAJ_Z;
      b_raw   = 19'sd16384 + e22 - e00 - e11;
      pr[0] = p_yxz; pr[1] = s_xz; pr[2] = s_yz;
    end
  end

  // clamp base, split pairs into sign and magnitude
  always_comb begin
    base_c = (b_raw < 19'sd1) ? rmq_pkg::BaseW'(1) : b_raw[rmq_pkg::BaseW-1:0];
    side_c.major = major_c;
    for (int i = 0; i < L; i++) begin
      side_c.neg[i] = pr[i][18];
      side_c.mag[i] = pr[i][18] ? 17'(-pr[i]) : pr[i][16:0];
    end
  end

  logic                      prep_valid_r;
  logic [rmq_pkg::BaseW-1:0] prep_base_r;
  rmq_pkg::sq_side_t         prep_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (adv) begin
      prep_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_base_r <= base_c;
      prep_side_r <= side_c;
    end
  end

  // ---------------- square root chain ----------------
  localparam int NS = rmq_pkg::SqrtSteps;

  logic                        sq_valid [NS+1];
  logic [rmq_pkg::RadW-1:0]    sq_rad   [NS+1];
  logic [rmq_pkg::SqRemW-1:0]  sq_rem   [NS+1];
  logic [rmq_pkg::RootW-1:0]   sq_root  [NS+1];
  logic [SQW-1:0]              sq_side  [NS+1];

  assign sq_valid[0] = prep_valid_r;
  assign sq_rad[0]   = {1'b0, prep_base_r, 20'd0};
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = prep_side_r;

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    rmq_sqrt_cell #(
      .RADW (rmq_pkg::RadW),
      .REMW (rmq_pkg::SqRemW),
      .ROOTW(rmq_pkg::RootW),
      .SIDEW(SQW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_in(sq_valid[g]),
      .rad_in  (sq_rad[g]),
      .rem_in  (sq_rem[g]),
      .root_in (sq_root[g]),
      .side_in (sq_side[g]),
      .valid_r (sq_valid[g+1]),
      .rad_r   (sq_rad[g+1]),
      .rem_r   (sq_rem[g+1]),
      .root_r  (sq_root[g+1]),
      .side_r  (sq_side[g+1])
    );
  end

  // ---------------- rounding stage ----------------
  rmq_pkg::sq_side_t         sq_out;
  logic [rmq_pkg::RootW-1:0] s_round;
  logic [rmq_pkg::RootW:0]   f_plus;
  logic [L-1:0][rmq_pkg::NumW-1:0] numer;
  rmq_pkg::dv_side_t         dv_c;

  always_comb begin
    sq_out  = sq_side[NS];
    s_round = sq_root[NS] + rmq_pkg::RootW'(
                {{(rmq_pkg::SqRemW-1){1'b0}},
                 (sq_rem[NS] > {{(rmq_pkg::SqRemW-rmq_pkg::RootW){1'b0}}, sq_root[NS]})});
    f_plus  = {1'b0, sq_root[NS]} + (rmq_pkg::RootW+1)'(8);
    for (int i = 0; i < L; i++) begin
      numer[i] = {sq_out.mag[i], 17'd0}
               + {{(rmq_pkg::NumW-rmq_pkg::RootW){1'b0}}, s_round};
    end
    dv_c.major     = sq_out.major;
    dv_c.neg       = sq_out.neg;
    dv_c.major_val = f_plus[rmq_pkg::MajW+3:4];
  end

  logic                            rnd_valid_r;
  logic [rmq_pkg::DenW-1:0]        rnd_den_r;
  logic [L-1:0][rmq_pkg::NumW-1:0] rnd_num_r;
  rmq_pkg::dv_side_t               rnd_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_valid_r <= 1'b0;
    end else if (adv) begin
      rnd_valid_r <= sq_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rnd_den_r  <= {s_round, 1'b0};
      rnd_num_r  <= numer;
      rnd_side_r <= dv_c;
    end
  end

  // ---------------- divider chain ----------------
  localparam int ND = rmq_pkg::DivSteps;
  localparam int HI = rmq_pkg::NumW - ND;

  logic                                        dv_valid [ND+1];
  logic [rmq_pkg::DenW-1:0]                    dv_den   [ND+1];
  logic [L-1:0][ND-1:0]                        dv_num   [ND+1];
  logic [L-1:0][rmq_pkg::DenW-1:0]             dv_rem   [ND+1];
  logic [L-1:0][rmq_pkg::QuoW-1:0]             dv_quo   [ND+1];
  logic [DVW-1:0]                              dv_side  [ND+1];

  // top dividend bits already sit below the divisor
  always_comb begin
    for (int i = 0; i < L; i++) begin
      dv_num[0][i] = rnd_num_r[i][ND-1:0];
      dv_rem[0][i] = {{(rmq_pkg::DenW-HI){1'b0}}, rnd_num_r[i][rmq_pkg::NumW-1:ND]};
      dv_quo[0][i] = '0;
    end
  end

  assign dv_valid[0] = rnd_valid_r;
  assign dv_den[0]   = rnd_den_r;
  assign dv_side[0]  = rnd_side_r;

  for (genvar g = 0; g < ND; g++) begin : g_div
    rmq_div_cell #(
      .LANES(L),
      .NUMW (ND),
      .DENW (rmq_pkg::DenW),
      .QUOW (rmq_pkg::QuoW),
      .SIDEW(DVW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .valid_in(dv_valid[g]),
      .den_in  (dv_den[g]),
      .num_in  (dv_num[g]),
      .rem_in  (dv_rem[g]),
      .quo_in  (dv_quo[g]),
      .side_in (dv_side[g]),
      .valid_r (dv_valid[g+1]),
      .den_r   (dv_den[g+1]),
      .num_r   (dv_num[g+1]),
      .rem_r   (dv_rem[g+1]),
      .quo_r   (dv_quo[g+1]),
      .side_r  (dv_side[g+1])
    );
  end

  // ---------------- saturate and place ----------------
  rmq_pkg::dv_side_t       dv_out;
  logic [L-1:0][rmq_pkg::DataW-1:0] lane_q;
  logic [rmq_pkg::DataW-1:0] maj_q;
  rmq_pkg::out_req_t       out_c;

  always_comb begin
    dv_out = dv_side[ND];
    maj_q  = {1'b0, dv_out.major_val};
    for (int i = 0; i < L; i++) begin
      if (!dv_out.neg[i]) begin
        lane_q[i] = (dv_quo[ND][i] > rmq_pkg::QuoW'(32767)) ? 16'h7fff
                  : dv_quo[ND][i][rmq_pkg::DataW-1:0];
      end else begin
        lane_q[i] = (dv_quo[ND][i] > rmq_pkg::QuoW'(32768)) ? 16'h8000
                  : 16'(-dv_quo[ND][i][rmq_pkg::DataW-1:0]);
      end
    end
  end

  always_comb begin
    unique case (dv_out.major)
      rmq_pkg::MAJ_W: begin
        out_c.quat_w = maj_q;     out_c.quat_x = lane_q[0];
        out_c.quat_y = lane_q[1]; out_c.quat_z = lane_q[2];
      end
      rmq_pkg::MAJ_X: begin
        out_c.quat_w = lane_q[0]; out_c.quat_x = maj_q;
        out_c.quat_y = lane_q[1]; out_c.quat_z = lane_q[2];
      end
      rmq_pkg::MAJ_Y: begin
        out_c.quat_w = lane_q[0]; out_c.quat_x = lane_q[1];
        out_c.quat_y = maj_q;     out_c.quat_z = lane_q[2];
      end
      default: begin
        out_c.quat_w = lane_q[0]; out_c.quat_x = lane_q[1];
        out_c.quat_y = lane_q[2]; out_c.quat_z = maj_q;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_c;
    end
  end

endmodule

/* rtl/rmq_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One restoring square root step: brings down two radicand bits, one root bit.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
  parameter int RADW  = rmq_pkg::RadW,
  parameter int REMW  = rmq_pkg::SqRemW,
  parameter int ROOTW = rmq_pkg::RootW,
  parameter int SIDEW = $bits(rmq_pkg::sq_side_t)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             valid_in,
  input  logic [RADW-1:0]  rad_in,
  input  logic [REMW-1:0]  rem_in,
  input  logic [ROOTW-1:0] root_in,
  input  logic [SIDEW-1:0] side_in,
  output logic             valid_r,
  output logic [RADW-1:0]  rad_r,
  output logic [REMW-1:0]  rem_r,
  output logic [ROOTW-1:0] root_r,
  output logic [SIDEW-1:0] side_r
);

  logic [REMW+1:0]  cur;
  logic [REMW+1:0]  trial;
  logic [REMW+1:0]  diff;
  logic             ge;
  logic [REMW-1:0]  rem_nxt;
  logic [ROOTW-1:0] root_nxt;
  logic [RADW-1:0]  rad_nxt;

  // trial subtract of 4*root+1
  always_comb begin
    cur      = {rem_in, rad_in[RADW-1 -: 2]};
    trial    = {{(REMW-ROOTW){1'b0}}, root_in, 2'b01};
    ge       = (cur >= trial);
    diff     = cur - trial;
    rem_nxt  = ge ? diff[REMW-1:0] : cur[REMW-1:0];
    root_nxt = {root_in[ROOTW-2:0], ge};
    rad_nxt  = {rad_in[RADW-3:0], 2'b00};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_in;
    end
  end

endmodule

/* rtl/rmq_div_cell.sv */
// ----------------------------------------------------------------------------
// rmq_div_cell
// One restoring division step for every lane against a shared divisor.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
  parameter int LANES = rmq_pkg::Lanes,
  parameter int NUMW  = rmq_pkg::DivSteps,
  parameter int DENW  = rmq_pkg::DenW,
  parameter int QUOW  = rmq_pkg::QuoW,
  parameter int SIDEW = $bits(rmq_pkg::dv_side_t)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       valid_in,
  input  logic [DENW-1:0]            den_in,
  input  logic [LANES-1:0][NUMW-1:0] num_in,
  input  logic [LANES-1:0][DENW-1:0] rem_in,
  input  logic [LANES-1:0][QUOW-1:0] quo_in,
  input  logic [SIDEW-1:0]           side_in,
  output logic                       valid_r,
  output logic [DENW-1:0]            den_r,
  output logic [LANES-1:0][NUMW-1:0] num_r,
  output logic [LANES-1:0][DENW-1:0] rem_r,
  output logic [LANES-1:0][QUOW-1:0] quo_r,
  output logic [SIDEW-1:0]           side_r
);

  logic [LANES-1:0][DENW:0]   cur;
  logic [LANES-1:0][DENW:0]   diff;
  logic [LANES-1:0]           ge;
  logic [LANES-1:0][NUMW-1:0] num_nxt;
  logic [LANES-1:0][DENW-1:0] rem_nxt;
  logic [LANES-1:0][QUOW-1:0] quo_nxt;

  // bring down one dividend bit per lane
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      cur[i]     = {rem_in[i], num_in[i][NUMW-1]};
      ge[i]      = (cur[i] >= {1'b0, den_in});
      diff[i]    = cur[i] - {1'b0, den_in};
      rem_nxt[i] = ge[i] ? diff[i][DENW-1:0] : cur[i][DENW-1:0];
      quo_nxt[i] = {quo_in[i][QUOW-2:0], ge[i]};
      num_nxt[i] = {num_in[i][NUMW-2:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= den_in;
      num_r  <= num_nxt;
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      side_r <= side_in;
    end
  end

endmodule

/* rtl/rmq_checker.sv */
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks on the conversion pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module rmq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input rmq_pkg::in_req_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input rmq_pkg::out_req_t out_data
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  // chain comes up empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // an empty output never blocks the input side
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
